// File: rtl/japs_pkg.sv
// Shared constants, types and helpers for the joystick axis percent scaler.
package japs_pkg;

  localparam int ADC_BITS      = 12;
  localparam int PERCENT_SCALE = 100;
  localparam int PCT_W         = $clog2(PERCENT_SCALE + 1);
  localparam int NUM_W         = ADC_BITS + PCT_W;
  localparam int OUT_W         = PCT_W + 1;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER   = 2'd0,
    CFG_MAX      = 2'd1,
    CFG_DEADZONE = 2'd2,
    CFG_INVERT   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } japs_tag_t;

  function automatic logic [PCT_W-1:0] pct_clamp(input logic [PCT_W-1:0] q,
                                                 input logic sat);
    pct_clamp = (sat || (q > PCT_W'(PERCENT_SCALE))) ? PCT_W'(PERCENT_SCALE) : q;
  endfunction

endpackage

// File: rtl/joystick_axis_percent_scaler_core.sv
// Top level: config registers, span and deadzone stages around two pipelined dividers.
//
// Converts one raw ADC count per cycle into a signed deflection in percent.
// A sample is taken whenever start is high; busy never rises, so a new sample
// may follow in every cycle. Each result appears on out_deflection for one
// cycle with out_valid, in sample order, after its sample has passed through
// one input register, two 8-stage restoring dividers (span scaling, then
// deadzone stretch) and one output register. The receiver cannot stall the
// pipeline. Write configuration only while no sample is in flight.
module joystick_axis_percent_scaler_core
  import japs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ADC_BITS-1:0]        in_sample,
  output logic                       out_valid,
  output logic signed [OUT_W-1:0]    out_deflection,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [ADC_BITS-1:0]        cfg_data
);

  localparam int LATENCY = 2 * (PCT_W + 1) + 2;

  logic [ADC_BITS-1:0] center_r;
  logic [ADC_BITS-1:0] max_r;
  logic [PCT_W-1:0]    dz_r;
  logic                inv_r;

  logic                s0_vld_r;
  logic [ADC_BITS-1:0] s0_sample_r;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_deflection_r;

  logic                gt;
  logic                lt;
  logic [ADC_BITS-1:0] diff_a;
  logic [NUM_W-1:0]    num_a;
  logic [ADC_BITS-1:0] den_a;
  japs_tag_t           tag_a_in;
  japs_tag_t           tag_a_out;
  logic [PCT_W-1:0]    quo_a;
  logic                sat_a;

  logic [PCT_W-1:0]    mag_a;
  logic [PCT_W-1:0]    diff_b;
  logic [PCT_W-1:0]    den_b7;
  logic [NUM_W-1:0]    num_b;
  logic [ADC_BITS-1:0] den_b;
  japs_tag_t           tag_b_in;
  japs_tag_t           tag_b_out;
  logic [PCT_W-1:0]    quo_b;
  logic                sat_b;

  logic [PCT_W-1:0]    mag_f;
  logic                neg_f;
  logic [OUT_W-1:0]    mag_ext;
  logic [OUT_W-1:0]    out_deflection_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= ADC_BITS'(2048);
      max_r    <= ADC_BITS'(4095);
      dz_r     <= '0;
      inv_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER:   center_r <= cfg_data;
        CFG_MAX:      max_r    <= cfg_data;
        CFG_DEADZONE: dz_r     <= cfg_data[PCT_W-1:0];
        CFG_INVERT:   inv_r    <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_sample_r <= in_sample;
  end

  always_comb begin
    gt       = s0_sample_r > center_r;
    lt       = s0_sample_r < center_r;
    diff_a   = gt ? (s0_sample_r - center_r) : (center_r - s0_sample_r);
    num_a    = NUM_W'(diff_a * PERCENT_SCALE);
    den_a    = gt ? (max_r - center_r) : center_r;
    tag_a_in = '{valid: s0_vld_r, neg: lt, zero: gt ? (max_r <= center_r) : !lt};
  end

  japs_div u_div_span (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (tag_a_in),
    .num_i (num_a),
    .den_i (den_a),
    .tag_o (tag_a_out),
    .quo_o (quo_a),
    .sat_o (sat_a)
  );

  always_comb begin
    mag_a    = pct_clamp(quo_a, sat_a);
    diff_b   = mag_a - dz_r;
    num_b    = NUM_W'(diff_b * PERCENT_SCALE);
    den_b7   = PCT_W'(PERCENT_SCALE) - dz_r;
    den_b    = ADC_BITS'(den_b7);
    tag_b_in = '{valid: tag_a_out.valid,
                 neg:   tag_a_out.neg,
                 zero:  tag_a_out.zero || (mag_a <= dz_r) ||
                        (dz_r >= PCT_W'(PERCENT_SCALE))};
  end

  japs_div u_div_dz (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (tag_b_in),
    .num_i (num_b),
    .den_i (den_b),
    .tag_o (tag_b_out),
    .quo_o (quo_b),
    .sat_o (sat_b)
  );

  always_comb begin
    mag_f              = tag_b_out.zero ? '0 : pct_clamp(quo_b, sat_b);
    neg_f              = ((mag_f != '0) && tag_b_out.neg) ^ inv_r;
    mag_ext            = OUT_W'(mag_f);
    out_deflection_nxt = neg_f ? (OUT_W'(0) - mag_ext) : mag_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tag_b_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_deflection_r <= out_deflection_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_deflection = out_deflection_r;

`ifndef NO_ASSERTIONS
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result transfer without a matching sample transfer");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_deflection <= 8'sd100) && (out_deflection >= -8'sd100))
    else $error("deflection out of range");

  a_full_deadzone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (dz_r >= PCT_W'(PERCENT_SCALE))) |-> (out_deflection == '0))
    else $error("nonzero deflection with full deadzone");
`endif

endmodule

// File: rtl/japs_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating flag on overflow.
module japs_div
  import japs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  japs_tag_t           tag_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [ADC_BITS-1:0] den_i,
  output japs_tag_t           tag_o,
  output logic [PCT_W-1:0]    quo_o,
  output logic                sat_o
);

  logic [PCT_W:0]        vld_r;
  logic [PCT_W:0]        neg_r;
  logic [PCT_W:0]        zero_r;
  logic [PCT_W:0]        sat_r;
  logic [NUM_W-1:0]      rem_r [0:PCT_W-1];
  logic [ADC_BITS-1:0]   den_r [0:PCT_W-1];
  logic [PCT_W-1:0]      quo_r [0:PCT_W];
  logic                  sat_nxt;

  assign sat_nxt = num_i >= {den_i, {PCT_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PCT_W-1:0], tag_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    neg_r    <= {neg_r[PCT_W-1:0], tag_i.neg};
    zero_r   <= {zero_r[PCT_W-1:0], tag_i.zero};
    sat_r    <= {sat_r[PCT_W-1:0], sat_nxt};
    rem_r[0] <= num_i;
    den_r[0] <= den_i;
    quo_r[0] <= '0;
  end

  for (genvar k = 1; k <= PCT_W; k++) begin : g_step
    logic [NUM_W-1:0] trial;
    logic             fit;

    assign trial = {{PCT_W{1'b0}}, den_r[k-1]} << (PCT_W - k);
    assign fit   = rem_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      quo_r[k] <= {quo_r[k-1][PCT_W-2:0], fit};
    end

    if (k < PCT_W) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= fit ? (rem_r[k-1] - trial) : rem_r[k-1];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign tag_o = '{valid: vld_r[PCT_W], neg: neg_r[PCT_W], zero: zero_r[PCT_W]};
  assign quo_o = quo_r[PCT_W];
  assign sat_o = sat_r[PCT_W];

endmodule
